>>> design/sil_pkg.sv
package sil_pkg;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

endpackage

>>> design/sorted_index_list.sv
// Sorted list of signed words held in one synchronous RAM (one write, one read port).
// A refused request, or an insert into an empty list, answers in the cycle after start; an
// insert walks down from the top entry, one RAM read a cycle; a delete walks up from the position.
// One request at a time: busy is high until the done strobe; the receiver cannot stall.
// Synchronous reset empties the list; the RAM is not cleared.
module sorted_index_list
  import sil_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               req_type,
  input  logic signed [31:0] value,
  input  logic [5:0]         position,
  input  logic               batch_last,
  output logic               busy,
  output logic               done,
  output logic [1:0]         status,
  output logic [6:0]         entry_count,
  output logic [5:0]         where_done,
  output logic signed [31:0] removed_value,
  output logic               batch_done
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_INS, S_PUT, S_DEL} state_t;

  state_t               state;
  logic [CW-1:0]        count;
  logic [AW-1:0]        sp;
  logic                 pend;
  logic [AW-1:0]        paddr;
  logic [AW-1:0]        last;
  logic [AW-1:0]        pos;
  logic signed [31:0]   val;
  logic                 blast;

  logic [31:0]          mem [CAPACITY];
  logic [31:0]          rdata;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [31:0]          wdata;
  logic                 less;

  assign busy = (state != S_IDLE);
  assign less = ($signed(rdata) < val);

  always_ff @(posedge clk) begin
    rdata <= mem[sp];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // The write trails the read by two addresses, so a walk never reads what it has just written.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = val;
    case (state)
      S_IDLE: begin
        if (start && req_type == REQ_INSERT && count == '0) begin
          we    = 1'b1;
          wdata = value;
        end
      end
      S_INS: begin
        if (pend) begin
          we    = 1'b1;
          waddr = paddr + AW'(1);
          wdata = less ? val : rdata;
        end
      end
      S_PUT: begin
        we = 1'b1;
      end
      S_DEL: begin
        if (pend && paddr != pos) begin
          we    = 1'b1;
          waddr = paddr - AW'(1);
          wdata = rdata;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            val   <= value;
            blast <= batch_last;
            pend  <= 1'b0;
            if (req_type == REQ_INSERT) begin
              if (count == CW'(CAPACITY)) begin
                done          <= 1'b1;
                status        <= ST_FULL;
                entry_count   <= 7'(count);
                where_done    <= '0;
                removed_value <= '0;
                batch_done    <= batch_last;
              end else if (count == '0) begin
                count         <= CW'(1);
                done          <= 1'b1;
                status        <= ST_DONE;
                entry_count   <= 7'd1;
                where_done    <= '0;
                removed_value <= '0;
                batch_done    <= batch_last;
              end else begin
                sp    <= AW'(count - CW'(1));
                state <= S_INS;
              end
            end else begin
              if (32'(position) >= 32'(count)) begin
                done          <= 1'b1;
                status        <= ST_RANGE;
                entry_count   <= 7'(count);
                where_done    <= '0;
                removed_value <= '0;
                batch_done    <= batch_last;
              end else begin
                sp    <= AW'(position);
                pos   <= AW'(position);
                last  <= AW'(count - CW'(1));
                state <= S_DEL;
              end
            end
          end
        end
        S_INS: begin
          pend  <= 1'b1;
          paddr <= sp;
          sp    <= sp - AW'(1);
          if (pend) begin
            if (less) begin
              count         <= count + CW'(1);
              done          <= 1'b1;
              status        <= ST_DONE;
              entry_count   <= 7'(count + CW'(1));
              where_done    <= 6'(paddr + AW'(1));
              removed_value <= '0;
              batch_done    <= blast;
              pend          <= 1'b0;
              state         <= S_IDLE;
            end else if (paddr == '0) begin
              // Every stored entry moved up: the new value becomes the first entry.
              pend  <= 1'b0;
              state <= S_PUT;
            end
          end
        end
        S_PUT: begin
          count         <= count + CW'(1);
          done          <= 1'b1;
          status        <= ST_DONE;
          entry_count   <= 7'(count + CW'(1));
          where_done    <= '0;
          removed_value <= '0;
          batch_done    <= blast;
          state         <= S_IDLE;
        end
        S_DEL: begin
          pend  <= 1'b1;
          paddr <= sp;
          sp    <= sp + AW'(1);
          if (pend) begin
            if (paddr == pos) begin
              removed_value <= rdata;
            end
            if (paddr == last) begin
              count       <= count - CW'(1);
              done        <= 1'b1;
              status      <= ST_DONE;
              entry_count <= 7'(count - CW'(1));
              where_done  <= 6'(pos);
              batch_done  <= blast;
              pend        <= 1'b0;
              state       <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/sil_checker.sv
module sil_checker
  import sil_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [1:0]         status,
  input logic [6:0]         entry_count,
  input logic [5:0]         where_done,
  input logic signed [31:0] removed_value
);

  // A result only ever follows a request that was taken.
  a_done_follows_request: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result strobe without a request in progress");

  // The walk always ends with a result.
  a_busy_ends_with_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (entry_count == 7'(CAPACITY)))
    else $error("full refusal while the list is not full");

  a_refusal_clean: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_DONE) |-> (where_done == '0 && removed_value == '0))
    else $error("refused request reports a position or value");

endmodule

bind sorted_index_list sil_checker #(.CAPACITY(CAPACITY)) u_sil_checker (.*);
